// ===== src/tsfb_pkg.sv =====
package tsfb_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SRC0_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC0_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SRC1_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SRC1_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ALPHA_MODE  = 3'd4;

  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 13;
  localparam int COORD_W    = 14;
  localparam int CHAN_W     = 8;
  localparam int QUOT_W     = 8;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 32;

  localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'd255;

  // one source sample with its local position
  typedef struct packed {
    logic [CHAN_W-1:0]         alpha;
    logic [CHAN_W-1:0]         red;
    logic [CHAN_W-1:0]         green;
    logic [CHAN_W-1:0]         blue;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } sample_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

endpackage

// ===== src/tsfb_divider.sv =====
module tsfb_divider #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 32
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [NUM_W-1:0]               num,
  input  logic [DEN_W-1:0]               den,
  output logic [tsfb_pkg::QUOT_W-1:0]    quot
);
  import tsfb_pkg::*;

  localparam int CMP_W = NUM_W + QUOT_W;

  // restoring division, one quotient bit per stage, msb first
  logic [NUM_W-1:0]  rem [0:QUOT_W];
  logic [DEN_W-1:0]  dv  [0:QUOT_W];
  logic [QUOT_W-1:0] qp  [0:QUOT_W];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign qp[0]  = '0;

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    localparam int SH = QUOT_W - 1 - k;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] rext;
    logic             take;

    assign dsh  = CMP_W'(dv[k]) << SH;
    assign rext = CMP_W'(rem[k]);
    assign take = rext >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? NUM_W'(rext - dsh) : rem[k];
        dv[k+1]  <= dv[k];
        qp[k+1]  <= qp[k] | (take ? (QUOT_W'(1) << SH) : '0);
      end
    end
  end

  assign quot = qp[QUOT_W];

endmodule

// ===== src/two_source_feather_blend.sv =====
// two_source_feather_blend
// blends two bgra source samples into one output pixel per transaction.
// input stream: s_tvalid/s_tready/s_tdata carries both samples with their
// local coordinates inside their own images; the feeder does the raster walk.
// a source counts when 0 <= x < width and 0 <= y < height; in feather mode
// it weighs min(x+1,w-x)*min(y+1,h-y), in alpha mode 1 when alpha > 127.
// output stream: m_tvalid/m_tready/m_tdata gives the weighted mean of bgr,
// rounded half up, with alpha 255, or all zeros when no weight is present.
// configuration: cfg_wen/cfg_index/cfg_data writes a register;
// write only while no transaction is in flight.
// throughput: one pixel per cycle unless the receiver stalls; fully pipelined.
// pipeline: from the accepting edge of the input transaction, data passes
// through 13 register stages: four stages of weight, product and sum
// work, eight stages of the restoring divider (one quotient bit per
// stage), then the output register.
// reset clears the valid bits and loads the register defaults (1024 x 1024
// images, feather mode). when the receiver stalls, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
module two_source_feather_blend #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  // cfg
  input  logic                              cfg_wen,
  input  logic [tsfb_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [tsfb_pkg::REG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // fields from bit 0: src0_local_x, src0_local_y, src0_blue, src0_green,
  // src0_red, src0_alpha, src1_local_x, src1_local_y, src1_blue, src1_green,
  // src1_red, src1_alpha
  input  logic [tsfb_pkg::IN_DATA_W-1:0]    s_tdata,
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // fields from bit 0: out_blue, out_green, out_red, out_alpha
  output logic [tsfb_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import tsfb_pkg::*;

  // dimension width must hold both a 13 bit register and MAX_DIM
  localparam int DIM_W  = ($clog2(MAX_DIM + 1) > REG_DATA_W + 1) ?
                          $clog2(MAX_DIM + 1) : REG_DATA_W + 1;
  localparam int WGT_W  = 2 * DIM_W;
  localparam int TOT_W  = WGT_W + 1;
  localparam int SUM_W  = WGT_W + CHAN_W + 1;
  localparam int NUM_W  = SUM_W + 2;
  localparam int DEN_W  = TOT_W + 1;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  // configuration registers
  logic [REG_DATA_W-1:0] src0_width, src0_height, src1_width, src1_height;
  logic                  alpha_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      src0_width  <= REG_DATA_W'(1024);
      src0_height <= REG_DATA_W'(1024);
      src1_width  <= REG_DATA_W'(1024);
      src1_height <= REG_DATA_W'(1024);
      alpha_mode  <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_SRC0_WIDTH:  src0_width  <= cfg_data;
        REG_SRC0_HEIGHT: src0_height <= cfg_data;
        REG_SRC1_WIDTH:  src1_width  <= cfg_data;
        REG_SRC1_HEIGHT: src1_height <= cfg_data;
        REG_ALPHA_MODE:  alpha_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: pipeline moves whenever the output slot is free or taken
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  sample_t smp0, smp1;
  assign smp0 = s_tdata[59:0];
  assign smp1 = s_tdata[119:60];

  // clamped dimensions
  logic [DIM_W-1:0] d0w, d0h, d1w, d1h;
  assign d0w = (DIM_W'(src0_width)  > DIM_MAX) ? DIM_MAX : DIM_W'(src0_width);
  assign d0h = (DIM_W'(src0_height) > DIM_MAX) ? DIM_MAX : DIM_W'(src0_height);
  assign d1w = (DIM_W'(src1_width)  > DIM_MAX) ? DIM_MAX : DIM_W'(src1_width);
  assign d1h = (DIM_W'(src1_height) > DIM_MAX) ? DIM_MAX : DIM_W'(src1_height);

  // inside test and edge distance for one axis
  function automatic logic axis_in(input logic signed [COORD_W-1:0] c,
                                   input logic [DIM_W-1:0] d);
    axis_in = !c[COORD_W-1] && (DIM_W'(c[COORD_W-2:0]) < d);
  endfunction

  function automatic logic [DIM_W-1:0] axis_fac(input logic signed [COORD_W-1:0] c,
                                                input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] cp, lo, hi;
    cp = DIM_W'(c[COORD_W-2:0]);
    lo = cp + DIM_W'(1);
    hi = d - cp;
    axis_fac = (lo < hi) ? lo : hi;
  endfunction

  // stage 1: coverage and per-axis factors
  logic             v1, in0_1, in1_1, am_1, a0_1, a1_1;
  logic [DIM_W-1:0] f0x, f0y, f1x, f1y;
  rgb_t             c0_1, c1_1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in0_1 <= axis_in(smp0.x, d0w) && axis_in(smp0.y, d0h);
      in1_1 <= axis_in(smp1.x, d1w) && axis_in(smp1.y, d1h);
      f0x   <= axis_fac(smp0.x, d0w);
      f0y   <= axis_fac(smp0.y, d0h);
      f1x   <= axis_fac(smp1.x, d1w);
      f1y   <= axis_fac(smp1.y, d1h);
      am_1  <= alpha_mode;
      a0_1  <= smp0.alpha[CHAN_W-1];
      a1_1  <= smp1.alpha[CHAN_W-1];
      c0_1  <= '{red: smp0.red, green: smp0.green, blue: smp0.blue};
      c1_1  <= '{red: smp1.red, green: smp1.green, blue: smp1.blue};
    end
  end

  // stage 2: source weights
  logic             v2;
  logic [WGT_W-1:0] w0_2, w1_2;
  rgb_t             c0_2, c1_2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w0_2 <= !in0_1 ? '0 : (am_1 ? WGT_W'(a0_1) : f0x * f0y);
      w1_2 <= !in1_1 ? '0 : (am_1 ? WGT_W'(a1_1) : f1x * f1y);
      c0_2 <= c0_1;
      c1_2 <= c1_1;
    end
  end

  // stage 3: weighted channel sums and total weight
  logic             v3;
  logic [SUM_W-1:0] sb_3, sg_3, sr_3;
  logic [TOT_W-1:0] tot_3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  // products are formed at the full sum width so that wide weights keep all bits
  always_ff @(posedge clk) begin
    if (en) begin
      sb_3  <= SUM_W'(w0_2) * c0_2.blue  + SUM_W'(w1_2) * c1_2.blue;
      sg_3  <= SUM_W'(w0_2) * c0_2.green + SUM_W'(w1_2) * c1_2.green;
      sr_3  <= SUM_W'(w0_2) * c0_2.red   + SUM_W'(w1_2) * c1_2.red;
      tot_3 <= TOT_W'(w0_2) + TOT_W'(w1_2);
    end
  end

  // stage 4: rounding numerator 2s+W and denominator 2W
  logic             v4, any_4;
  logic [NUM_W-1:0] nb_4, ng_4, nr_4;
  logic [DEN_W-1:0] den_4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nb_4  <= {sb_3, 1'b0} + NUM_W'(tot_3);
      ng_4  <= {sg_3, 1'b0} + NUM_W'(tot_3);
      nr_4  <= {sr_3, 1'b0} + NUM_W'(tot_3);
      den_4 <= {tot_3, 1'b0};
      any_4 <= tot_3 != '0;
    end
  end

  // divider stages, valid and coverage travel alongside
  logic [QUOT_W-1:0] qb, qg, qr;
  logic              vd  [0:QUOT_W-1];
  logic              anyd[0:QUOT_W-1];

  tsfb_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_b (
    .clk(clk), .en(en), .num(nb_4), .den(den_4), .quot(qb));
  tsfb_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_g (
    .clk(clk), .en(en), .num(ng_4), .den(den_4), .quot(qg));
  tsfb_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_r (
    .clk(clk), .en(en), .num(nr_4), .den(den_4), .quot(qr));

  for (genvar k = 0; k < QUOT_W; k++) begin : g_track
    always_ff @(posedge clk) begin
      if (rst) vd[k] <= 1'b0;
      else if (en) vd[k] <= (k == 0) ? v4 : vd[(k == 0) ? 0 : k-1];
    end
    always_ff @(posedge clk) begin
      if (en) anyd[k] <= (k == 0) ? any_4 : anyd[(k == 0) ? 0 : k-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vd[QUOT_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= anyd[QUOT_W-1] ? {ALPHA_FULL, qr, qg, qb} : '0;
    end
  end

endmodule

// ===== tb/two_source_feather_blend_tb.sv =====
module two_source_feather_blend_tb;
  import tsfb_pkg::*;

  localparam int PIPE_DEPTH = 13;
  localparam int MAX_SIDE   = 4096;
  localparam int STALL_CAP  = 4000;
  localparam int RANDOM_N   = 1750;

  // register indexes with no register behind them
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // one input transaction, fields in the order they sit in s_tdata
  typedef struct {
    logic signed [COORD_W-1:0] x0, y0;
    logic [CHAN_W-1:0]         b0, g0, r0, a0;
    logic signed [COORD_W-1:0] x1, y1;
    logic [CHAN_W-1:0]         b1, g1, r1, a1;
  } pixel_pair_t;

  typedef struct {
    logic [CHAN_W-1:0] b, g, r, a;
  } blend_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  always #2 clk = ~clk;

  two_source_feather_blend u_dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // shadow copy of the configuration registers
  logic [REG_DATA_W-1:0] img0_w, img0_h, img1_w, img1_h;
  logic                  use_alpha;

  blend_px_t blend_queue[$];
  int  err_count = 0;
  int  px_sent = 0;
  int  px_seen = 0;
  int  idle_cycles = 0;
  bit  sink_idle_on = 1'b1;
  bit  src_idle_on = 1'b1;
  bit  hold_sink = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on pixel %0d: %s got %0d expected %0d", px_seen, what, got, want);
    err_count++;
  endtask

  // weight of one source, 0 when outside its image
  function automatic longint src_weight(input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y,
                                        input logic [REG_DATA_W-1:0] wr,
                                        input logic [REG_DATA_W-1:0] hr,
                                        input logic [CHAN_W-1:0] a);
    longint w, h, xi, yi, fx, fy;
    w = (wr > MAX_SIDE) ? MAX_SIDE : wr;
    h = (hr > MAX_SIDE) ? MAX_SIDE : hr;
    xi = x;
    yi = y;
    if (xi < 0 || yi < 0 || xi >= w || yi >= h) return 0;
    if (use_alpha) return (a > 8'd127) ? 1 : 0;
    fx = (xi + 1 < w - xi) ? xi + 1 : w - xi;
    fy = (yi + 1 < h - yi) ? yi + 1 : h - yi;
    return fx * fy;
  endfunction

  function automatic logic [CHAN_W-1:0] rounded_mean(input longint w0, input longint w1,
                                                     input logic [CHAN_W-1:0] c0,
                                                     input logic [CHAN_W-1:0] c1);
    longint s, q;
    s = w0 * c0 + w1 * c1;
    q = (2 * s + w0 + w1) / (2 * (w0 + w1));
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic blend_px_t blend_pixel(input pixel_pair_t p);
    blend_px_t o;
    longint w0, w1;
    w0 = src_weight(p.x0, p.y0, img0_w, img0_h, p.a0);
    w1 = src_weight(p.x1, p.y1, img1_w, img1_h, p.a1);
    if (w0 + w1 == 0) begin
      o = '{8'd0, 8'd0, 8'd0, 8'd0};
    end else begin
      o.b = rounded_mean(w0, w1, p.b0, p.b1);
      o.g = rounded_mean(w0, w1, p.g0, p.g1);
      o.r = rounded_mean(w0, w1, p.r0, p.r1);
      o.a = ALPHA_FULL;
    end
    return o;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_pair(input pixel_pair_t p);
    return {p.a1, p.r1, p.g1, p.b1, p.y1, p.x1, p.a0, p.r0, p.g0, p.b0, p.y0, p.x0};
  endfunction

  // register write at the falling edge, shadow copy follows
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_SRC0_WIDTH:  img0_w = val;
      REG_SRC0_HEIGHT: img0_h = val;
      REG_SRC1_WIDTH:  img1_w = val;
      REG_SRC1_HEIGHT: img1_h = val;
      REG_ALPHA_MODE:  use_alpha = val[0];
      default: ;
    endcase
  endtask

  // offer one transaction, wait for the handshake; expected result queued at acceptance
  task automatic send_pair(input pixel_pair_t p, input bit with_want, input blend_px_t want);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk);
    end
    s_tdata <= pack_pair(p);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    blend_queue.insert(blend_queue.size(), with_want ? want : blend_pixel(p));
    px_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (blend_queue.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(input int dim);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return COORD_W'($urandom);
    if (k == 1) return COORD_W'(-int'($urandom_range(1, 8192)));
    if (k == 2) return COORD_W'(dim + int'($urandom_range(0, 3)));
    if (k == 3) return $urandom_range(0, 1) ? COORD_W'(0) : COORD_W'(dim - 1);
    return COORD_W'($urandom_range(0, (dim > MAX_SIDE ? MAX_SIDE : dim) + 1));
  endfunction

  function automatic pixel_pair_t random_pair;
    pixel_pair_t p;
    p.x0 = pick_coord(img0_w); p.y0 = pick_coord(img0_h);
    p.x1 = pick_coord(img1_w); p.y1 = pick_coord(img1_h);
    p.b0 = CHAN_W'($urandom); p.g0 = CHAN_W'($urandom);
    p.r0 = CHAN_W'($urandom); p.a0 = CHAN_W'($urandom);
    p.b1 = CHAN_W'($urandom); p.g1 = CHAN_W'($urandom);
    p.r1 = CHAN_W'($urandom); p.a1 = CHAN_W'($urandom);
    return p;
  endfunction

  // output side: random stalls, plus random hold-off bursts
  always @(negedge clk) begin
    if (rst || hold_sink) m_tready <= 1'b0;
    else if (sink_idle_on && $urandom_range(0, 7) == 0) m_tready <= 1'b0;
    else m_tready <= 1'b1;
  end

  always @(negedge clk) begin
    int n;
    if (!rst && sink_idle_on && !hold_sink && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 14);
      hold_sink <= 1'b1;
      repeat (n) @(negedge clk);
      hold_sink <= 1'b0;
    end
  end

  // compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    blend_px_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (blend_queue.size() == 0) begin
        $display("unexpected output transaction %h", m_tdata);
        err_count++;
      end else begin
        want = blend_queue.pop_front();
        if (m_tdata[7:0] !== want.b) report_mismatch("blue", m_tdata[7:0], want.b);
        if (m_tdata[15:8] !== want.g) report_mismatch("green", m_tdata[15:8], want.g);
        if (m_tdata[23:16] !== want.r) report_mismatch("red", m_tdata[23:16], want.r);
        if (m_tdata[31:24] !== want.a) report_mismatch("alpha", m_tdata[31:24], want.a);
      end
      px_seen++;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_CAP) begin
      $display("watchdog expired with %0d results outstanding", blend_queue.size());
      $display("Verification failed");
      $finish;
    end
  end

  // directed rows: typed expectations only where they are obvious
  typedef struct {
    pixel_pair_t px;
    bit          typed;
    blend_px_t   want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(input pixel_pair_t px, input bit typed, input blend_px_t want);
    dir_row_t row;
    row.px = px;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  initial begin
    pixel_pair_t p, q;
    blend_px_t zero_px;
    int phase, hold;
    zero_px = '{8'd0, 8'd0, 8'd0, 8'd0};
    img0_w = 13'd1024; img0_h = 13'd1024; img1_w = 13'd1024; img1_h = 13'd1024;
    use_alpha = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // center of both images after reset, equal weights
    p = '{14'sd512, 14'sd512, 8'd10, 8'd20, 8'd30, 8'd200,
          14'sd512, 14'sd512, 8'd11, 8'd21, 8'd31, 8'd0};
    add_row(p, 1'b0, zero_px);
    // negative coordinates on both sides: no weight
    p = '{-14'sd1, 14'sd0, 8'hff, 8'hff, 8'hff, 8'hff,
          14'sd0, -14'sd8192, 8'hff, 8'hff, 8'hff, 8'hff};
    add_row(p, 1'b1, zero_px);
    // right on the far edge, outside
    p = '{14'sd1024, 14'sd0, 8'd1, 8'd2, 8'd3, 8'd4,
          14'sd8191, 14'sd8191, 8'd5, 8'd6, 8'd7, 8'd8};
    add_row(p, 1'b1, zero_px);
    // only the first source counts: its colour passes through
    p = '{14'sd0, 14'sd0, 8'd255, 8'd0, 8'd128, 8'd0,
          -14'sd5, 14'sd3, 8'd9, 8'd9, 8'd9, 8'd9};
    add_row(p, 1'b1, '{8'd255, 8'd0, 8'd128, ALPHA_FULL});
    // only the second source counts, last pixel of its image
    p = '{14'sd2000, 14'sd0, 8'd9, 8'd9, 8'd9, 8'd9,
          14'sd1023, 14'sd1023, 8'd0, 8'd255, 8'd77, 8'd0};
    add_row(p, 1'b1, '{8'd0, 8'd255, 8'd77, ALPHA_FULL});
    // extremes of the channels, uneven weights
    p = '{14'sd0, 14'sd0, 8'd255, 8'd255, 8'd255, 8'd255,
          14'sd511, 14'sd511, 8'd0, 8'd0, 8'd0, 8'd0};
    add_row(p, 1'b0, zero_px);
    foreach (dir_rows[i]) send_pair(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
    drain();

    // alpha mode, threshold on both sides of 127
    write_reg(REG_ALPHA_MODE, 13'd1);
    p = '{14'sd5, 14'sd5, 8'd100, 8'd0, 8'd0, 8'd128,
          14'sd5, 14'sd5, 8'd201, 8'd0, 8'd0, 8'd127};
    send_pair(p, 1'b1, '{8'd100, 8'd0, 8'd0, ALPHA_FULL});
    p.a1 = 8'd255;
    send_pair(p, 1'b1, '{8'd151, 8'd0, 8'd0, ALPHA_FULL});
    p.a0 = 8'd0; p.a1 = 8'd127;
    send_pair(p, 1'b1, zero_px);
    drain();

    // zero sizes and oversized sizes, unknown register index
    write_reg(REG_ALPHA_MODE, 13'd0);
    write_reg(REG_SRC0_WIDTH, 13'd0);
    write_reg(REG_SRC1_HEIGHT, 13'd8191);
    write_reg(REG_UNUSED_HI, 13'd1);
    write_reg(REG_UNUSED_LO, 13'd0);
    p = '{14'sd0, 14'sd0, 8'd50, 8'd50, 8'd50, 8'd255,
          14'sd4095, 14'sd4095, 8'd1, 8'd2, 8'd3, 8'd4};
    send_pair(p, 1'b0, zero_px);
    p.x1 = 14'sd4096;
    send_pair(p, 1'b1, zero_px);
    p.x1 = 14'sd100; p.y1 = 14'sd4096;
    send_pair(p, 1'b1, zero_px);
    drain();

    // random phases over several settings; the last phase runs with no idling
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_SRC0_WIDTH, 13'd1); write_reg(REG_SRC0_HEIGHT, 13'd1);
          write_reg(REG_SRC1_WIDTH, 13'd4096); write_reg(REG_SRC1_HEIGHT, 13'd4096);
        end
        1: begin
          write_reg(REG_SRC0_WIDTH, 13'd8191); write_reg(REG_SRC0_HEIGHT, 13'd4097);
          write_reg(REG_SRC1_WIDTH, 13'd2); write_reg(REG_SRC1_HEIGHT, 13'd3);
        end
        2: write_reg(REG_ALPHA_MODE, 13'd1);
        3: begin
          write_reg(REG_ALPHA_MODE, 13'd0);
          write_reg(REG_SRC0_WIDTH, REG_DATA_W'($urandom_range(1, 64)));
          write_reg(REG_SRC0_HEIGHT, REG_DATA_W'($urandom_range(1, 64)));
          write_reg(REG_SRC1_WIDTH, REG_DATA_W'($urandom_range(1, 64)));
          write_reg(REG_SRC1_HEIGHT, REG_DATA_W'($urandom_range(1, 64)));
        end
        4: begin
          write_reg(REG_SRC0_WIDTH, REG_DATA_W'($urandom_range(0, 8191)));
          write_reg(REG_SRC1_WIDTH, REG_DATA_W'($urandom_range(0, 8191)));
        end
        5: write_reg(REG_ALPHA_MODE, 13'd1);
        default: begin
          write_reg(REG_ALPHA_MODE, 13'd0);
          write_reg(REG_SRC0_WIDTH, 13'd37); write_reg(REG_SRC0_HEIGHT, 13'd29);
          src_idle_on = 1'b0;
          sink_idle_on = 1'b0;
        end
      endcase
      // phase 1: long receiver hold-off so the pipeline fills and s_tready drops
      if (phase == 1) begin
        hold = 0;
        fork
          begin
            force_hold: begin
              sink_idle_on = 1'b0;
              wait (!hold_sink);
              hold_sink = 1'b1;
              while (hold < 60) begin
                @(negedge clk);
                hold++;
              end
              hold_sink = 1'b0;
              sink_idle_on = 1'b1;
            end
          end
          for (int k = 0; k < 40; k++) send_pair(random_pair(), 1'b0, zero_px);
        join
      end
      for (int k = 0; k < RANDOM_N / 7; k++) begin
        q = random_pair();
        send_pair(q, 1'b0, zero_px);
      end
      drain();
    end

    repeat (PIPE_DEPTH * 2) @(negedge clk);
    $display("%0d pixels sent, %0d checked, over feather and alpha modes", px_sent, px_seen);
    $display("image sizes covered zero, one, small, max and beyond max");
    if (err_count == 0 && blend_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", err_count, blend_queue.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tsfb_pkg.sv
src/tsfb_divider.sv
src/two_source_feather_blend.sv
tb/two_source_feather_blend_tb.sv
